// File: hdl/mwmh_pkg.sv
// Package for the multiset window min-hash block.
// Holds the sizes, field widths, register codes and the controller state type.
// No dependencies.
package mwmh_pkg;

    localparam int VOCAB    = 4096;
    localparam int MAX_MULT = 16;
    localparam int WINDOW   = 64;
    localparam int SLOTS    = MAX_MULT - 1;

    localparam int WORD_W = 12;
    localparam int SLOT_W = 4;
    localparam int ID_W   = 32;
    localparam int HASH_W = 32;
    localparam int MULT_W = 5;
    localparam int POS_W  = 6;
    localparam int LEN_W  = POS_W + 1;
    localparam int CFG_W  = 31;
    localparam int CNT_AW = $clog2(VOCAB);
    localparam int SUB_AW = WORD_W + SLOT_W;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 48;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WORD = 1'b1;

    localparam logic REG_HASH_MULT = 1'b0;
    localparam logic REG_HASH_ADD  = 1'b1;

    localparam logic [CFG_W-1:0] HASH_MULT_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] HASH_ADD_RESET  = CFG_W'(0);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_MULT,
        S_CMP,
        S_FETCH,
        S_EMIT
    } state_t;

endpackage

// File: hdl/multiset_window_minhash.sv
// Top level of the multiset window min-hash block.
// Count, substitute and window memories with a read-modify-write controller.
// Depends on mwmh_pkg.
// A load item is written straight into the substitute memory; a window item passes through count read,
// count write and substitute read, multiply and compare, in that order.
// One load item is taken every cycle while idle; no item is taken until a window item is done.
// On the item that ends a window the window buffer is walked position by position, a fetch
// then an emit for each, and the emit of a matching position waits while the output is stalled.
// After reset a clearing pass zeroes all 4096 count memory entries; no item is taken then.
module multiset_window_minhash
    import mwmh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // word[11:0], repeat_slot[15:12], substitute_id[47:16]
    input  logic [IN_W-1:0]   s_tdata,
    // op[0]
    input  logic              s_tuser,
    // last_word
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // min_hash[31:0], multiplicity[36:32], position[42:37], zero[47:43]
    output logic [OUT_W-1:0]  m_tdata,
    // last
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [MULT_W-1:0] cnt_mem [VOCAB];
    logic [ID_W-1:0]   sub_mem [2**SUB_AW];
    logic [WORD_W-1:0] ww_mem  [WINDOW];

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  hash_mult_reg, hash_add_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [HASH_W-1:0] best_hash_reg, best_hash_next;
    logic [WORD_W-1:0] best_word_reg, best_word_next;
    logic [MULT_W-1:0] best_mult_reg, best_mult_next;
    logic [POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [POS_W-1:0]  walk_idx_reg, walk_idx_next;
    logic [LEN_W-1:0]  walk_len_reg, walk_len_next;
    logic [CNT_AW-1:0] clr_idx_reg, clr_idx_next;
    logic              out_valid_reg, out_valid_next;

    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic [MULT_W-1:0] cnt_rd_reg;
    logic [ID_W-1:0]   sub_rd_reg;
    logic [WORD_W-1:0] ww_rd_reg;
    logic [MULT_W-1:0] mult_reg, mult_next;
    logic [HASH_W-1:0] prod_reg, prod_next;
    logic [HASH_W-1:0] out_hash_reg;
    logic [MULT_W-1:0] out_mult_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;

    logic [WORD_W-1:0] in_word;
    logic [SLOT_W-1:0] in_slot;
    logic [ID_W-1:0]   in_sub;
    logic              in_acc;
    logic              word_acc;
    logic              load_we;
    logic              cfg_we;

    logic              cnt_we;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [MULT_W-1:0] cnt_wdata;
    logic [MULT_W-1:0] cnt_sat;
    logic [SUB_AW-1:0] sub_raddr;
    logic [ID_W-1:0]   hash_id;
    logic [HASH_W-1:0] hash_val;
    logic              window_end;
    logic              walk_match;
    logic              out_free;
    logic              emit_ok;
    logic              walk_done;
    logic              out_load;

    assign in_word  = s_tdata[WORD_W-1:0];
    assign in_slot  = s_tdata[WORD_W+SLOT_W-1:WORD_W];
    assign in_sub   = s_tdata[WORD_W+SLOT_W+ID_W-1:WORD_W+SLOT_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign word_acc = in_acc && (s_tuser == OP_WORD);
    assign load_we  = in_acc && (s_tuser == OP_LOAD) && (in_slot < SLOT_W'(SLOTS));

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HASH_MULT) ? {1'b0, hash_mult_reg} : {1'b0, hash_add_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mult_reg <= HASH_MULT_RESET;
            hash_add_reg  <= HASH_ADD_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_HASH_MULT)
            begin
                hash_mult_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                hash_add_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (word_acc)
        begin
            cnt_rd_reg <= cnt_mem[in_word];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            sub_mem[{in_word, in_slot}] <= in_sub;
        end
        if (state_reg == S_COUNT)
        begin
            sub_rd_reg <= sub_mem[sub_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_acc)
        begin
            ww_mem[pos_reg] <= in_word;
        end
        if (state_reg == S_FETCH)
        begin
            ww_rd_reg <= ww_mem[walk_idx_reg];
        end
    end

    assign cnt_sat    = (cnt_rd_reg == MULT_W'(MAX_MULT)) ? cnt_rd_reg : cnt_rd_reg + MULT_W'(1);
    assign sub_raddr  = {word_reg, SLOT_W'(cnt_sat - MULT_W'(2))};
    assign hash_id    = (mult_reg <= MULT_W'(1)) ? {{(ID_W-WORD_W){1'b0}}, word_reg} : sub_rd_reg;
    assign hash_val   = prod_reg + {1'b0, hash_add_reg};
    assign window_end = last_reg || (pos_reg == POS_W'(WINDOW - 1));
    assign walk_match = (ww_rd_reg == best_word_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign emit_ok    = !walk_match || out_free;
    assign walk_done  = ({1'b0, walk_idx_reg} + LEN_W'(1)) == walk_len_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == CNT_AW'(VOCAB - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (word_acc)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                state_next = S_MULT;
            end
            S_MULT:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = window_end ? S_FETCH : S_IDLE;
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = walk_done ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        cnt_we         = 1'b0;
        cnt_waddr      = word_reg;
        cnt_wdata      = cnt_sat;
        clr_idx_next   = clr_idx_reg;
        mult_next      = mult_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        best_hash_next = best_hash_reg;
        best_word_next = best_word_reg;
        best_mult_next = best_mult_reg;
        last_pos_next  = last_pos_reg;
        walk_idx_next  = walk_idx_reg;
        walk_len_next  = walk_len_reg;
        out_load       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                cnt_wdata    = '0;
                clr_idx_next = clr_idx_reg + CNT_AW'(1);
            end
            S_COUNT:
            begin
                cnt_we    = 1'b1;
                mult_next = cnt_sat;
            end
            S_MULT:
            begin
                prod_next = {1'b0, hash_mult_reg} * hash_id;
            end
            S_CMP:
            begin
                if ((pos_reg == '0) || (hash_val <= best_hash_reg))
                begin
                    best_hash_next = hash_val;
                    best_word_next = word_reg;
                    best_mult_next = mult_reg;
                end
                if (word_reg == best_word_next)
                begin
                    last_pos_next = pos_reg;
                end
                if (window_end)
                begin
                    walk_len_next = {1'b0, pos_reg} + LEN_W'(1);
                    walk_idx_next = '0;
                    pos_next      = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            S_EMIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = ww_rd_reg;
                cnt_wdata = '0;
                out_load  = walk_match && out_free;
                if (emit_ok)
                begin
                    walk_idx_next = walk_idx_reg + POS_W'(1);
                end
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            pos_reg       <= '0;
            best_hash_reg <= '0;
            best_word_reg <= '0;
            best_mult_reg <= '0;
            last_pos_reg  <= '0;
            walk_idx_reg  <= '0;
            walk_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            pos_reg       <= pos_next;
            best_hash_reg <= best_hash_next;
            best_word_reg <= best_word_next;
            best_mult_reg <= best_mult_next;
            last_pos_reg  <= last_pos_next;
            walk_idx_reg  <= walk_idx_next;
            walk_len_reg  <= walk_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_acc)
        begin
            word_reg <= in_word;
            last_reg <= s_tlast;
        end
        mult_reg <= mult_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            out_hash_reg <= best_hash_reg;
            out_mult_reg <= best_mult_reg;
            out_pos_reg  <= walk_idx_reg;
            out_last_reg <= (walk_idx_reg == last_pos_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-HASH_W-MULT_W-POS_W){1'b0}}, out_pos_reg, out_mult_reg,
                       out_hash_reg};
    assign m_tlast  = out_last_reg;

    a_no_count_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !cnt_we)
        else $error("count memory written while idle");

    a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MULT |-> (mult_reg != '0) && (mult_reg <= MULT_W'(MAX_MULT)))
        else $error("occurrence count out of range");

    a_emit_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == S_EMIT) && (ww_rd_reg == best_word_reg))
        else $error("result loaded without a matching word");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH || state_reg == S_EMIT) |-> {1'b0, walk_idx_reg} < walk_len_reg)
        else $error("window walk past its length");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (walk_idx_reg == last_pos_reg) |=> state_reg == S_IDLE || state_reg == S_FETCH)
        else $error("walk stalled after final result");

endmodule
